>>> sv/lors_pkg.sv
`timescale 1ns / 1ps

package lors_pkg;

	// Fixed field widths of the stream items.
	localparam int SAMPLE_W    = 20;
	localparam int SLOPE_W     = 32;
	localparam int S_TDATA_W   = 24;
	localparam int M_TDATA_W   = 32;

	typedef enum logic [2:0] {
		ST_ACC,
		ST_LOAD,
		ST_MUL_A,
		ST_MUL_B,
		ST_SIGN,
		ST_DIV,
		ST_OUT
	} lors_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic acc_en;
		logic load_a;
		logic load_b;
		logic mul_step;
		logic mul_top;
		logic abs_load;
		logic div_step;
		logic out_load;
	} lors_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;
	} lors_sts_t;

endpackage

>>> sv/lors_ctrl.sv
`timescale 1ns / 1ps

module lors_ctrl import lors_pkg::*; #(
	parameter int MUL_STEPS = 36,
	parameter int DIV_STEPS = 91
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	input  logic      s_tlast,
	output logic      s_tready,
	input  lors_sts_t sts,
	output lors_cmd_t cmd
);

	localparam int MAX_STEPS = (MUL_STEPS > DIV_STEPS) ? MUL_STEPS : DIV_STEPS;
	localparam int CNT_W     = $clog2(MAX_STEPS);

	lors_state_t       state_q, state_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACC;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_ACC: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.acc_en = 1'b1;
					if (s_tlast) begin
						state_d = ST_LOAD;
					end
				end
			end
			ST_LOAD: begin
				cmd.load_a = 1'b1;
				cnt_d      = '0;
				state_d    = ST_MUL_A;
			end
			ST_MUL_A: begin
				cmd.mul_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(MUL_STEPS - 1)) begin
					cmd.mul_top = 1'b1;
					cmd.load_b  = 1'b1;
					cnt_d       = '0;
					state_d     = ST_MUL_B;
				end
			end
			ST_MUL_B: begin
				cmd.mul_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(MUL_STEPS - 1)) begin
					cmd.mul_top = 1'b1;
					cnt_d       = '0;
					state_d     = ST_SIGN;
				end
			end
			ST_SIGN: begin
				cmd.abs_load = 1'b1;
				cnt_d        = '0;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					cnt_d   = '0;
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_ACC;
				end
			end
			default: begin
				state_d = ST_ACC;
				cnt_d   = '0;
			end
		endcase
	end

`ifndef SYNTH
	a_last_starts_fit: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> state_q == ST_LOAD)
		else $error("last item did not start the fit");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result loaded over an unaccepted one");

	a_div_ends: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV && cnt_q == CNT_W'(DIV_STEPS - 1) |=> state_q == ST_OUT)
		else $error("division did not end after its step count");

	a_one_phase: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.acc_en, cmd.load_a, cmd.mul_step, cmd.abs_load,
			cmd.div_step, cmd.out_load}))
		else $error("datapath commands overlap");
`endif

endmodule

>>> sv/lors_dp.sv
`timescale 1ns / 1ps

module lors_dp import lors_pkg::*; #(
	parameter int MAX_PAIRS = 65535,
	parameter int FRAC_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  lors_cmd_t                 cmd,
	output lors_sts_t                 sts,
	input  logic signed [SAMPLE_W-1:0] sample,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [SLOPE_W-1:0] slope,
	output logic                      fit_valid
);

	localparam int CW     = $clog2(MAX_PAIRS + 1);
	localparam int SX_W   = SAMPLE_W + CW;
	localparam int SDX_W  = SAMPLE_W + 1 + CW;
	localparam int SXX_W  = 2 * SAMPLE_W + CW;
	localparam int SXDX_W = 2 * SAMPLE_W + 1 + CW;
	localparam int P_W    = 2 * SAMPLE_W + 3 + 2 * CW;
	localparam int MB     = SX_W;
	localparam int D_W    = P_W + FRAC_BITS;
	localparam int QW     = SLOPE_W + 1;

	localparam logic [QW-1:0]      Q_NEG_LIM = QW'(1) << (SLOPE_W - 1);
	localparam logic [SLOPE_W-1:0] SLOPE_MIN = {1'b1, {(SLOPE_W - 1){1'b0}}};
	localparam logic [SLOPE_W-1:0] SLOPE_MAX = {1'b0, {(SLOPE_W - 1){1'b1}}};

	// Series accumulators.
	logic signed [SAMPLE_W-1:0] prev_q;
	logic                       have_prev_q;
	logic [CW-1:0]              cnt_q;
	logic signed [SX_W-1:0]     sx_q;
	logic signed [SDX_W-1:0]    sdx_q;
	logic signed [SXX_W-1:0]    sxx_q;
	logic signed [SXDX_W-1:0]   sxdx_q;

	logic signed [SAMPLE_W:0]     dx;
	logic signed [2*SAMPLE_W-1:0] prod_xx;
	logic signed [2*SAMPLE_W:0]   prod_xdx;
	logic                         pair_ok;

	assign dx       = SAMPLE_W'(sample) - prev_q;
	assign prod_xx  = prev_q * prev_q;
	assign prod_xdx = prev_q * dx;
	assign pair_ok  = have_prev_q && (cnt_q != CW'(MAX_PAIRS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			have_prev_q <= 1'b0;
			cnt_q       <= '0;
			sx_q        <= '0;
			sdx_q       <= '0;
			sxx_q       <= '0;
			sxdx_q      <= '0;
		end else if (cmd.out_load) begin
			prev_q      <= '0;
			have_prev_q <= 1'b0;
			cnt_q       <= '0;
			sx_q        <= '0;
			sdx_q       <= '0;
			sxx_q       <= '0;
			sxdx_q      <= '0;
		end else if (cmd.acc_en) begin
			if (pair_ok) begin
				cnt_q  <= cnt_q + 1'b1;
				sx_q   <= sx_q + SX_W'(prev_q);
				sdx_q  <= sdx_q + SDX_W'(dx);
				sxx_q  <= sxx_q + SXX_W'(prod_xx);
				sxdx_q <= sxdx_q + SXDX_W'(prod_xdx);
			end
			prev_q      <= sample;
			have_prev_q <= 1'b1;
		end
	end

	// Shift-and-add products: numerator and denominator built side by side.
	logic [MB-1:0]          mplier_q;
	logic signed [P_W-1:0]  mc_num_q, mc_den_q;
	logic signed [P_W-1:0]  num_q, den_q;
	logic signed [P_W-1:0]  add_num, add_den;

	assign add_num = mplier_q[0] ? mc_num_q : '0;
	assign add_den = mplier_q[0] ? mc_den_q : '0;

	// Long division of |num| * 2^FRAC_BITS by |den|.
	logic [D_W-1:0] div_q;
	logic [P_W-1:0] rem_q;
	logic [QW-1:0]  quo_q;
	logic           sat_q;
	logic           neg_q;
	logic [P_W:0]   trial, diff;
	logic [P_W-1:0] abs_num;

	assign abs_num = num_q[P_W-1] ? P_W'(-num_q) : P_W'(num_q);
	assign trial   = {rem_q, div_q[D_W-1]};
	assign diff    = trial - {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (cmd.load_a) begin
			mplier_q <= MB'(cnt_q);
			mc_num_q <= P_W'(sxdx_q);
			mc_den_q <= P_W'(sxx_q);
			num_q    <= '0;
			den_q    <= '0;
		end
		if (cmd.mul_step) begin
			// The top multiplier bit carries negative weight.
			if (cmd.mul_top) begin
				num_q <= num_q - add_num;
				den_q <= den_q - add_den;
			end else begin
				num_q <= num_q + add_num;
				den_q <= den_q + add_den;
			end
			if (cmd.load_b) begin
				mplier_q <= sx_q;
				mc_num_q <= -P_W'(sdx_q);
				mc_den_q <= -P_W'(sx_q);
			end else begin
				mplier_q <= mplier_q >> 1;
				mc_num_q <= mc_num_q <<< 1;
				mc_den_q <= mc_den_q <<< 1;
			end
		end
		if (cmd.abs_load) begin
			neg_q <= num_q[P_W-1] ^ den_q[P_W-1];
			div_q <= {abs_num, {FRAC_BITS{1'b0}}};
			den_q <= den_q[P_W-1] ? -den_q : den_q;
			rem_q <= '0;
			quo_q <= '0;
			sat_q <= 1'b0;
		end
		if (cmd.div_step) begin
			div_q <= div_q << 1;
			sat_q <= sat_q | quo_q[QW-1];
			if (!diff[P_W]) begin
				rem_q <= diff[P_W-1:0];
				quo_q <= {quo_q[QW-2:0], 1'b1};
			end else begin
				rem_q <= trial[P_W-1:0];
				quo_q <= {quo_q[QW-2:0], 1'b0};
			end
		end
	end

	// Saturation and result register.
	logic               fit_ok;
	logic [SLOPE_W-1:0] slope_sat;

	assign fit_ok = (cnt_q >= CW'(2)) && (den_q != '0);

	always_comb begin
		if (neg_q) begin
			if (sat_q || (quo_q > Q_NEG_LIM)) begin
				slope_sat = SLOPE_MIN;
			end else begin
				slope_sat = -quo_q[SLOPE_W-1:0];
			end
		end else begin
			if (sat_q || quo_q[QW-1] || quo_q[QW-2]) begin
				slope_sat = SLOPE_MAX;
			end else begin
				slope_sat = quo_q[SLOPE_W-1:0];
			end
		end
	end

	logic                      out_valid_q;
	logic signed [SLOPE_W-1:0] slope_q;
	logic                      fit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			slope_q <= fit_ok ? slope_sat : '0;
			fit_q   <= fit_ok;
		end
	end

	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign slope        = slope_q;
	assign fit_valid    = fit_q;

endmodule

>>> sv/lag_one_regression_slope.sv
`timescale 1ns / 1ps

// Least-squares slope of the step on the previous value over a series of signed
// Q3.16 samples, one sample per item on the slave side, with tlast marking the
// final sample. Every sample after the first forms a pair (x = previous sample,
// dx = step), and the count, sum x, sum dx, sum x*x and sum x*dx are kept exactly;
// pairs beyond MAX_PAIRS are ignored. Within a series an item is taken in every
// clock. The last item starts the fit: a controller runs a shift-and-add unit that
// forms numerator and denominator together, one multiplier bit per cycle over
// 20 + CW bits for each of two phases (CW = clog2(MAX_PAIRS + 1)), then a restoring
// divider that produces one quotient bit per cycle over 2*20 + 3 + 2*CW + FRAC_BITS
// bits. The slave side is therefore not ready after the last item until the fit
// is done and the result is loaded, plus however long an earlier result still
// waits on the master side. The result item carries the slope in Q15.16, truncated
// toward zero and saturated to 32 bits, with tuser set when the fit is valid; with
// fewer than two pairs or a zero denominator tuser is low and the slope is zero.
// The series then starts afresh.
module lag_one_regression_slope import lors_pkg::*; #(
	parameter int MAX_PAIRS = 65535,
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // [19:0] sample
	input  logic                 s_tlast,   // last_sample
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // [31:0] slope
	output logic                 m_tuser    // fit_valid
);

	localparam int CW        = $clog2(MAX_PAIRS + 1);
	localparam int MUL_STEPS = SAMPLE_W + CW;
	localparam int DIV_STEPS = 2 * SAMPLE_W + 3 + 2 * CW + FRAC_BITS;

	lors_cmd_t                 cmd;
	lors_sts_t                 sts;
	logic signed [SLOPE_W-1:0] slope;

	// The controller sequences accumulation, the two product phases and the
	// division; the datapath holds every sum and does the arithmetic.
	lors_ctrl #(
		.MUL_STEPS(MUL_STEPS),
		.DIV_STEPS(DIV_STEPS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tlast (s_tlast),
		.s_tready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	lors_dp #(
		.MAX_PAIRS(MAX_PAIRS),
		.FRAC_BITS(FRAC_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.sample   (s_tdata[SAMPLE_W-1:0]),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.slope    (slope),
		.fit_valid(m_tuser)
	);

	assign m_tdata = M_TDATA_W'(slope);

endmodule
